// ----- hw/rtl/c8x_pkg.sv -----
// ----------------------------------------------------------------------------
// c8x_pkg
// Shared constants, opcode codes and types for the instruction execute core.
// ----------------------------------------------------------------------------
package c8x_pkg;

  localparam int ADDR_W              = 12;
  localparam int INSTR_W             = 16;
  localparam int GPR_W               = 8;
  localparam int GPR_N               = 16;
  localparam int GPR_AW              = $clog2(GPR_N);
  localparam int STACK_DEPTH_DEFAULT = 16;

  localparam logic [ADDR_W-1:0] PC_START = 12'h200;
  localparam logic [ADDR_W-1:0] PC_STEP  = 12'd2;

  // top nibble of the instruction word
  localparam logic [3:0] OP_SYS     = 4'h0;
  localparam logic [3:0] OP_JP      = 4'h1;
  localparam logic [3:0] OP_CALL    = 4'h2;
  localparam logic [3:0] OP_SE_IMM  = 4'h3;
  localparam logic [3:0] OP_SNE_IMM = 4'h4;
  localparam logic [3:0] OP_SE_REG  = 4'h5;
  localparam logic [3:0] OP_LD_IMM  = 4'h6;
  localparam logic [3:0] OP_ADD_IMM = 4'h7;
  localparam logic [3:0] OP_ALU     = 4'h8;

  // low nibble of register-register operations
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] SUB_NONE = 4'h0;

  localparam logic [INSTR_W-1:0] INSTR_CLS = 16'h00E0;
  localparam logic [INSTR_W-1:0] INSTR_RET = 16'h00EE;

  typedef struct packed {
    logic              en;
    logic [GPR_AW-1:0] addr;
    logic [GPR_W-1:0]  data;
  } gpr_wr_t;

endpackage

// ----- hw/rtl/chip8_instruction_execute_top.sv -----
// ----------------------------------------------------------------------------
// chip8_instruction_execute_top
// Items pass a memory read stage, then an execute stage, before the result is
// valid. Throughput: one item per cycle while out_ready stays high; the register
// file and return store are read on accept and written back at execute, with write-through forwarding.
// Reset: pc loads 0x200, registers read as zero, stack level clears; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module chip8_instruction_execute_top
  import c8x_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [ADDR_W-1:0]  program_start,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [INSTR_W-1:0] instruction,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ADDR_W-1:0]  next_address,
  output logic               reg_write,
  output logic [GPR_AW-1:0]  reg_index,
  output logic [GPR_W-1:0]   reg_value,
  output logic               skipped,
  output logic               clear_display,
  output logic               unsupported,
  output logic               stack_fault
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam logic [LW-1:0] LEVEL_FULL = LW'(STACK_DEPTH);

  logic              in_fire;
  logic              s1_adv;
  logic [LW-1:0]     level;
  logic              is_call;
  logic              is_ret;
  logic              lvl_full;
  logic              lvl_empty;
  logic [LW-1:0]     level_dec;

  logic              s1_valid;
  logic [INSTR_W-1:0] s1_instr;
  logic              s1_push;
  logic              s1_fault;
  logic [AW-1:0]     s1_addr;

  logic [GPR_W-1:0]  rx;
  logic [GPR_W-1:0]  ry;
  logic [ADDR_W-1:0] stk_rd_data;
  gpr_wr_t           gpr_wr;

  logic [ADDR_W-1:0] pc;
  logic [ADDR_W-1:0] pc_adv;
  logic [ADDR_W-1:0] pc_new;
  logic              ex_wr;
  logic [GPR_W-1:0]  ex_val;
  logic              ex_skip;
  logic              ex_cls;
  logic              ex_unsup;
  logic              ex_fault;
  logic [3:0]        op;
  logic [3:0]        sub;
  logic [GPR_W-1:0]  kk;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_adv;
  assign in_fire   = in_valid && in_ready;

  // decode stage: stack level tracks the item in flight
  assign is_call   = instruction[15:12] == OP_CALL;
  assign is_ret    = instruction == INSTR_RET;
  assign lvl_full  = level >= LEVEL_FULL;
  assign lvl_empty = level == '0;
  assign level_dec = level - LW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      level    <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
        if (is_call && !lvl_full) begin
          level <= level + LW'(1);
        end else if (is_ret && !lvl_empty) begin
          level <= level_dec;
        end
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_instr <= instruction;
      s1_push  <= is_call && !lvl_full;
      s1_fault <= (is_call && lvl_full) || (is_ret && lvl_empty);
      s1_addr  <= level[AW-1:0];
    end
  end

  c8x_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (in_fire),
    .rd_addr_x (instruction[11:8]),
    .rd_addr_y (instruction[7:4]),
    .rd_data_x (rx),
    .rd_data_y (ry),
    .wr        (gpr_wr)
  );

  c8x_stack #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (s1_adv && s1_push),
    .wr_addr (s1_addr),
    .wr_data (pc_adv),
    .rd_en   (in_fire),
    .rd_addr (level_dec[AW-1:0]),
    .rd_data (stk_rd_data)
  );

  // execute stage
  assign op  = s1_instr[15:12];
  assign sub = s1_instr[3:0];
  assign kk  = s1_instr[7:0];

  always_comb begin
    pc_adv   = pc + PC_STEP;
    pc_new   = pc_adv;
    ex_wr    = 1'b0;
    ex_val   = '0;
    ex_skip  = 1'b0;
    ex_cls   = 1'b0;
    ex_unsup = 1'b0;
    ex_fault = 1'b0;
    case (op)
      OP_SYS: begin
        if (s1_instr == INSTR_CLS) begin
          ex_cls = 1'b1;
        end else if (s1_instr == INSTR_RET) begin
          if (s1_fault) begin
            ex_fault = 1'b1;
          end else begin
            pc_new = stk_rd_data;
          end
        end else begin
          ex_unsup = 1'b1;
        end
      end
      OP_JP: begin
        pc_new = s1_instr[ADDR_W-1:0];
      end
      OP_CALL: begin
        if (s1_fault) begin
          ex_fault = 1'b1;
        end else begin
          pc_new = s1_instr[ADDR_W-1:0];
        end
      end
      OP_SE_IMM:  ex_skip = rx == kk;
      OP_SNE_IMM: ex_skip = rx != kk;
      OP_SE_REG: begin
        if (sub != SUB_NONE) begin
          ex_unsup = 1'b1;
        end else begin
          ex_skip = rx == ry;
        end
      end
      OP_LD_IMM: begin
        ex_wr  = 1'b1;
        ex_val = kk;
      end
      OP_ADD_IMM: begin
        ex_wr  = 1'b1;
        ex_val = rx + kk;
      end
      OP_ALU: begin
        case (sub)
          ALU_MOV: begin
            ex_wr  = 1'b1;
            ex_val = ry;
          end
          ALU_AND: begin
            ex_wr  = 1'b1;
            ex_val = rx & ry;
          end
          ALU_XOR: begin
            ex_wr  = 1'b1;
            ex_val = rx ^ ry;
          end
          default: ex_unsup = 1'b1;
        endcase
      end
      default: ex_unsup = 1'b1;
    endcase
    if (ex_skip) begin
      pc_new = pc_adv + PC_STEP;
    end
  end

  assign gpr_wr.en   = s1_adv && ex_wr;
  assign gpr_wr.addr = s1_instr[11:8];
  assign gpr_wr.data = ex_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= PC_START;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pc <= program_start;
      end else if (s1_adv) begin
        pc <= pc_new;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      next_address  <= pc_new;
      reg_write     <= ex_wr;
      reg_index     <= ex_wr ? s1_instr[11:8] : '0;
      reg_value     <= ex_val;
      skipped       <= ex_skip;
      clear_display <= ex_cls;
      unsupported   <= ex_unsup;
      stack_fault   <= ex_fault;
    end
  end

endmodule

// ----- hw/rtl/c8x_regfile.sv -----
// ----------------------------------------------------------------------------
// c8x_regfile
// General register file: one write port, two registered read ports with
// write-through, per-entry valid bits so unwritten entries read as zero.
// ----------------------------------------------------------------------------
module c8x_regfile
  import c8x_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [GPR_AW-1:0] rd_addr_x,
  input  logic [GPR_AW-1:0] rd_addr_y,
  output logic [GPR_W-1:0]  rd_data_x,
  output logic [GPR_W-1:0]  rd_data_y,
  input  gpr_wr_t           wr
);

  logic [GPR_W-1:0] mem [GPR_N];
  logic [GPR_N-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && wr.addr == rd_addr_x) begin
        rd_data_x <= wr.data;
      end else begin
        rd_data_x <= vld[rd_addr_x] ? mem[rd_addr_x] : '0;
      end
      if (wr.en && wr.addr == rd_addr_y) begin
        rd_data_y <= wr.data;
      end else begin
        rd_data_y <= vld[rd_addr_y] ? mem[rd_addr_y] : '0;
      end
    end
  end

endmodule

// ----- hw/rtl/c8x_stack.sv -----
// ----------------------------------------------------------------------------
// c8x_stack
// Return address store: one write port, one registered read port with
// write-through so a return straight after a call sees the pushed address.
// ----------------------------------------------------------------------------
module c8x_stack
  import c8x_pkg::*;
#(
  parameter int DEPTH = STACK_DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [ADDR_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [ADDR_W-1:0] rd_data
);

  logic [ADDR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= (wr_en && wr_addr == rd_addr) ? wr_data : mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/c8x_checker.sv -----
// ----------------------------------------------------------------------------
// c8x_checker
// Port-level checks on the result channel of the execute core.
// ----------------------------------------------------------------------------
module c8x_checker
  import c8x_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ADDR_W-1:0] next_address,
  input logic              reg_write,
  input logic [GPR_AW-1:0] reg_index,
  input logic [GPR_W-1:0]  reg_value,
  input logic              skipped,
  input logic              clear_display,
  input logic              unsupported,
  input logic              stack_fault
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_address) && $stable(reg_value))
    else $error("result item changed while stalled");

  a_unsup_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && unsupported |-> !reg_write && !skipped && !stack_fault && !clear_display)
    else $error("unsupported item had side effects");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reg_write |-> reg_index == '0 && reg_value == '0)
    else $error("register fields not cleared without a write");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && (clear_display || stack_fault) |-> !reg_write && !skipped)
    else $error("control item also wrote or skipped");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind chip8_instruction_execute_top c8x_checker u_c8x_checker (.*);

// ----- tb/tb_chip8_instruction_execute_top.sv -----
// ----------------------------------------------------------------------------
// tb_chip8_instruction_execute_top
// Self-checking bench for the instruction execute core. Items go in and
// results come out over valid/ready channels with random gaps and stalls.
// Each accepted item is run through a behavioural executor that keeps its
// own pc, registers and return stack. The expected results are queued and
// compared field by field with what the core returns. A short table of
// directed items comes first, then phases of random items, each phase
// starting from a fresh program start address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_chip8_instruction_execute_top;
  import c8x_pkg::*;

  localparam int          DEPTH        = STACK_DEPTH_DEFAULT;
  localparam int          SAW          = $clog2(DEPTH);
  localparam int          RESET_CYCLES = 10;
  localparam int          N_PHASES     = 8;
  localparam int          PHASE_ITEMS  = 176;
  localparam int          LONG_HOLD    = 400;
  localparam int          DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [ADDR_W-1:0] next_address;
    logic              reg_write;
    logic [GPR_AW-1:0] reg_index;
    logic [GPR_W-1:0]  reg_value;
    logic              skipped;
    logic              clear_display;
    logic              unsupported;
    logic              stack_fault;
  } exec_result_t;

  typedef struct packed {
    logic [INSTR_W-1:0] w;
    logic               typed;
    exec_result_t       want;
  } vec_row_t;

  // flag bits in result order: skipped, clear_display, unsupported, stack_fault
  localparam logic [3:0]   F_NONE  = 4'b0000;
  localparam logic [3:0]   F_CLS   = 4'b0100;
  localparam logic [3:0]   F_UNSUP = 4'b0010;
  localparam logic [3:0]   F_FAULT = 4'b0001;
  localparam exec_result_t NO_RES  = '0;

  localparam int DIR_N = 25;
  localparam vec_row_t DIR_TAB [DIR_N] = '{
    {16'h00E0, 1'b1, 12'h202, 1'b0, 4'h0, 8'h00, F_CLS},
    {16'h00EE, 1'b1, 12'h204, 1'b0, 4'h0, 8'h00, F_FAULT},
    {16'hF123, 1'b1, 12'h206, 1'b0, 4'h0, 8'h00, F_UNSUP},
    {16'h6AFF, 1'b1, 12'h208, 1'b1, 4'hA, 8'hFF, F_NONE},
    {16'h7A01, 1'b1, 12'h20A, 1'b1, 4'hA, 8'h00, F_NONE},
    {16'h60FF, 1'b1, 12'h20C, 1'b1, 4'h0, 8'hFF, F_NONE},
    {16'h7F00, 1'b0, NO_RES},
    {16'h30FF, 1'b0, NO_RES},
    {16'h3000, 1'b0, NO_RES},
    {16'h4000, 1'b0, NO_RES},
    {16'h4A00, 1'b0, NO_RES},
    {16'h5AF0, 1'b0, NO_RES},
    {16'h50A0, 1'b0, NO_RES},
    {16'h5A01, 1'b0, NO_RES},
    {16'h8F00, 1'b0, NO_RES},
    {16'h8F02, 1'b0, NO_RES},
    {16'h8F03, 1'b0, NO_RES},
    {16'h8A0E, 1'b0, NO_RES},
    {16'h2FFE, 1'b0, NO_RES},
    {16'h1FFE, 1'b0, NO_RES},
    {16'h3F00, 1'b0, NO_RES},
    {16'h00EE, 1'b0, NO_RES},
    {16'h0000, 1'b0, NO_RES},
    {16'hFFFF, 1'b0, NO_RES},
    {16'h9AB0, 1'b0, NO_RES}
  };

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [ADDR_W-1:0]  program_start;
  logic               in_valid;
  logic               in_ready;
  logic [INSTR_W-1:0] instruction;
  logic               out_valid;
  logic               out_ready;
  logic [ADDR_W-1:0]  next_address;
  logic               reg_write;
  logic [GPR_AW-1:0]  reg_index;
  logic [GPR_W-1:0]   reg_value;
  logic               skipped;
  logic               clear_display;
  logic               unsupported;
  logic               stack_fault;

  // executor state
  logic [ADDR_W-1:0] exec_pc;
  logic [GPR_W-1:0]  exec_gpr [GPR_N];
  logic [ADDR_W-1:0] exec_stack [DEPTH];
  int unsigned       exec_depth;

  exec_result_t pending_results [$];
  int unsigned  issued;
  int unsigned  err_cnt = 0;
  int unsigned  cycle_cnt = 0;
  logic         no_gaps;
  logic         hold_req;
  logic         hold_done;

  chip8_instruction_execute_top #(
    .STACK_DEPTH(DEPTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .program_start(program_start),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .instruction  (instruction),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .next_address (next_address),
    .reg_write    (reg_write),
    .reg_index    (reg_index),
    .reg_value    (reg_value),
    .skipped      (skipped),
    .clear_display(clear_display),
    .unsupported  (unsupported),
    .stack_fault  (stack_fault)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic exec_result_t execute_instr(input logic [INSTR_W-1:0] w);
    exec_result_t r;
    logic [3:0]   op;
    logic [3:0]   x;
    logic [3:0]   y;
    logic [3:0]   n;
    logic [7:0]   kk;
    r  = '0;
    op = w[15:12];
    x  = w[11:8];
    y  = w[7:4];
    n  = w[3:0];
    kk = w[7:0];
    exec_pc = exec_pc + PC_STEP;
    case (op)
      OP_SYS: begin
        if (w == INSTR_CLS) begin
          r.clear_display = 1'b1;
        end else if (w == INSTR_RET) begin
          if (exec_depth == 0) begin
            r.stack_fault = 1'b1;
          end else begin
            exec_depth--;
            exec_pc = exec_stack[SAW'(exec_depth)];
          end
        end else begin
          r.unsupported = 1'b1;
        end
      end
      OP_JP: exec_pc = w[ADDR_W-1:0];
      OP_CALL: begin
        if (exec_depth >= DEPTH) begin
          r.stack_fault = 1'b1;
        end else begin
          exec_stack[SAW'(exec_depth)] = exec_pc;
          exec_depth++;
          exec_pc = w[ADDR_W-1:0];
        end
      end
      OP_SE_IMM:  r.skipped = (exec_gpr[x] == kk);
      OP_SNE_IMM: r.skipped = (exec_gpr[x] != kk);
      OP_SE_REG: begin
        if (n != SUB_NONE) r.unsupported = 1'b1;
        else r.skipped = (exec_gpr[x] == exec_gpr[y]);
      end
      OP_LD_IMM: begin
        r.reg_write = 1'b1;
        r.reg_value = kk;
      end
      OP_ADD_IMM: begin
        r.reg_write = 1'b1;
        r.reg_value = exec_gpr[x] + kk;
      end
      OP_ALU: begin
        r.reg_write = 1'b1;
        case (n)
          ALU_MOV: r.reg_value = exec_gpr[y];
          ALU_AND: r.reg_value = exec_gpr[x] & exec_gpr[y];
          ALU_XOR: r.reg_value = exec_gpr[x] ^ exec_gpr[y];
          default: begin
            r.reg_write   = 1'b0;
            r.unsupported = 1'b1;
          end
        endcase
      end
      default: r.unsupported = 1'b1;
    endcase
    if (r.skipped) exec_pc = exec_pc + PC_STEP;
    if (r.reg_write) begin
      r.reg_index = x;
      exec_gpr[x] = r.reg_value;
    end
    r.next_address = exec_pc;
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // well-formed words biased towards equal compares, plus some junk
  function automatic logic [INSTR_W-1:0] pick_op();
    logic [3:0]        x;
    logic [3:0]        y;
    logic [7:0]        kk;
    logic [ADDR_W-1:0] nnn;
    x   = 4'($urandom_range(0, 15));
    y   = 4'($urandom_range(0, 15));
    kk  = 8'($urandom);
    nnn = 12'($urandom);
    if ($urandom_range(0, 1) == 1) kk = exec_gpr[x];
    if ($urandom_range(0, 3) == 0) nnn = 12'hFFE + 12'($urandom_range(0, 1));
    case ($urandom_range(0, 13))
      0:  return {OP_SE_IMM, x, kk};
      1:  return {OP_SNE_IMM, x, kk};
      2:  return {OP_SE_REG, x, y, SUB_NONE};
      3:  return {OP_LD_IMM, x, kk};
      4:  return {OP_ADD_IMM, x, kk};
      5:  return {OP_ALU, x, y, ALU_MOV};
      6:  return {OP_ALU, x, y, ALU_AND};
      7:  return {OP_ALU, x, y, ALU_XOR};
      8:  return {OP_JP, nnn};
      9:  return INSTR_CLS;
      10: return {OP_SE_REG, x, y, 4'($urandom_range(1, 15))};
      11: return {OP_ALU, x, y, 4'($urandom_range(4, 15))};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic issue(input logic [INSTR_W-1:0] w, input logic typed,
                       input exec_result_t want);
    exec_result_t r;
    int unsigned  gap;
    in_valid    <= 1'b1;
    instruction <= w;
    do @(posedge clk); while (!in_ready);
    r = execute_instr(w);
    pending_results.push_back(typed ? want : r);
    issued++;
    gap = no_gaps ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_start(input logic [ADDR_W-1:0] addr);
    cfg_valid     <= 1'b1;
    program_start <= addr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    exec_pc = addr;
  endtask

  always @(posedge clk) begin : result_check
    exec_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected item, next_address %0h", next_address));
      end else begin
        want = pending_results.pop_front();
        check_field("next_address", 16'(next_address), 16'(want.next_address));
        check_field("reg_write", 16'(reg_write), 16'(want.reg_write));
        check_field("reg_index", 16'(reg_index), 16'(want.reg_index));
        check_field("reg_value", 16'(reg_value), 16'(want.reg_value));
        check_field("skipped", 16'(skipped), 16'(want.skipped));
        check_field("clear_display", 16'(clear_display), 16'(want.clear_display));
        check_field("unsupported", 16'(unsupported), 16'(want.unsupported));
        check_field("stack_fault", 16'(stack_fault), 16'(want.stack_fault));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : rx_side
    int unsigned stall;
    int unsigned calm;
    stall     = 0;
    calm      = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (calm != 0) calm--;
        else if ($urandom_range(0, 99) == 0) calm = $urandom_range(40, 160);
        else stall = idle_len();
      end
    end
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] start_addr;
    int unsigned       chain;
    int unsigned       target;
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    program_start = '0;
    in_valid      = 1'b0;
    instruction   = '0;
    no_gaps       = 1'b0;
    hold_req      = 1'b0;
    issued        = 0;
    exec_pc       = PC_START;
    exec_depth    = 0;
    foreach (exec_gpr[i]) exec_gpr[i] = '0;
    foreach (exec_stack[i]) exec_stack[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) issue(DIR_TAB[i].w, DIR_TAB[i].typed, DIR_TAB[i].want);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // sender waits for the core to drain before the start address moves
      in_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
      case (ph)
        0:       start_addr = 12'hFFF;
        1:       start_addr = 12'h000;
        2:       start_addr = 12'hFFE;
        3:       start_addr = PC_START;
        default: start_addr = 12'($urandom_range(0, 4095));
      endcase
      load_start(start_addr);
      no_gaps = (ph % 3 == 2);
      if (ph == 1) hold_req <= 1'b1;
      if (ph == 0) begin
        // fill the stack past its top, then unwind past empty
        repeat (DEPTH + 1) issue({OP_CALL, 12'($urandom)}, 1'b0, NO_RES);
        repeat (DEPTH + 2) issue(INSTR_RET, 1'b0, NO_RES);
      end
      target = issued + PHASE_ITEMS;
      while (issued < target) begin
        if ($urandom_range(0, 4) == 0) begin
          chain = $urandom_range(1, DEPTH + 2);
          repeat (chain) begin
            issue({OP_CALL, 12'($urandom)}, 1'b0, NO_RES);
            if ($urandom_range(0, 2) == 0) issue(pick_op(), 1'b0, NO_RES);
          end
          repeat (chain + $urandom_range(0, 1)) issue(INSTR_RET, 1'b0, NO_RES);
        end else begin
          repeat ($urandom_range(1, 8)) issue(pick_op(), 1'b0, NO_RES);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
